// File: hdl/dnsrae_pkg.sv
`timescale 1ns / 1ps
// Package for the DNS response answer extractor.
// Holds the parse phases, result kinds, record types and the result record.
// Depends on nothing.
package dnsrae_pkg;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_HDR,
        PH_QSTART,
        PH_QLEN,
        PH_QCHR,
        PH_QFIX,
        PH_ASTART,
        PH_APTR,
        PH_ALEN,
        PH_ACHR,
        PH_TYPEHI,
        PH_TYPELO,
        PH_FIX,
        PH_RDHI,
        PH_RDLO,
        PH_ADDR,
        PH_CSKIP
    } phase_t;

    localparam logic [2:0] KIND_QCHAR   = 3'd0;
    localparam logic [2:0] KIND_QEND    = 3'd1;
    localparam logic [2:0] KIND_ACHAR   = 3'd2;
    localparam logic [2:0] KIND_AEND    = 3'd3;
    localparam logic [2:0] KIND_MAP_Q   = 3'd4;
    localparam logic [2:0] KIND_MAP_INL = 3'd5;
    localparam logic [2:0] KIND_DONE    = 3'd6;
    localparam logic [2:0] KIND_ABORT   = 3'd7;

    localparam logic [15:0] TYPE_A     = 16'h0001;
    localparam logic [15:0] TYPE_AAAA  = 16'h001c;
    localparam logic [15:0] TYPE_CNAME = 16'h0005;

    localparam logic [7:0] CHAR_DOT = 8'h2e;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  name_char;
        logic [2:0]  query_index;
        logic        is_ipv6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic        last_of_run;
    } result_t;

    function automatic result_t make_result(logic [2:0] k, logic [7:0] ch, logic [2:0] qi,
                                            logic v6, logic [63:0] hi, logic [63:0] lo);
        result_t r;
        r.kind        = k;
        r.name_char   = ch;
        r.query_index = qi;
        r.is_ipv6     = v6;
        r.addr_high   = hi;
        r.addr_low    = lo;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

// File: hdl/dns_response_answer_extractor_unit.sv
`timescale 1ns / 1ps
// Top level of the DNS response answer extractor.
// Parses one message byte per transfer and queues the results it produces.
// Depends on dnsrae_pkg.

// The block takes one message byte per cycle and parses it in a single registered pass;
// each byte yields zero, one or two results, which wait in a four-entry result queue.
// A byte is taken whenever the queue has room for two results, so the block sustains
// one byte per cycle while the result side keeps up; bytes that give two results
// (an address mapping followed by done) drain at one result per cycle.
module dns_response_answer_extractor_unit #(
    parameter int MAX_QUERIES = 8,
    parameter int MAX_ANSWERS = 16,
    parameter int NAME_MAX    = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        msg_start,
    input  logic [15:0] msg_len,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  kind,
    output logic [7:0]  name_char,
    output logic [2:0]  query_index,
    output logic        is_ipv6,
    output logic [63:0] addr_high,
    output logic [63:0] addr_low,
    output logic        last_of_run
);
    import dnsrae_pkg::*;

    localparam int QW  = $clog2(MAX_QUERIES + 1);
    localparam int QIW = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
    localparam int AW  = $clog2(MAX_ANSWERS + 1);
    localparam int NW  = $clog2(NAME_MAX);
    localparam logic [NW-1:0] NAME_LIMIT = NW'(NAME_MAX - 1);

    phase_t        phase_reg, phase_next;
    logic [15:0]   pos_reg, pos_next;
    logic [15:0]   len_reg, len_next;
    logic [QW-1:0] qtot_reg, qtot_next;
    logic [AW-1:0] atot_reg, atot_next;
    logic [QW-1:0] cq_reg, cq_next;
    logic [AW-1:0] adone_reg, adone_next;
    logic [7:0]    label_reg, label_next;
    logic [NW-1:0] nlen_reg, nlen_next;
    logic [15:0]   fw_reg, fw_next;
    logic [15:0]   rtype_reg, rtype_next;
    logic [15:0]   skip_reg, skip_next;
    logic [63:0]   acc_hi_reg, acc_hi_next;
    logic [63:0]   acc_lo_reg, acc_lo_next;
    logic [QIW-1:0] src_reg, src_next;
    logic          inl_reg, inl_next;
    logic [15:0]   qoff_reg [MAX_QUERIES];

    logic           off_we;
    logic [QIW-1:0] off_idx;

    result_t     res_a [2];
    logic [1:0]  nres;
    logic        accept;

    result_t     fifo_reg [4];
    logic [1:0]  wr_reg, rd_reg;
    logic [2:0]  cnt_reg;
    logic        pop;

    assign accept = item_valid && item_ready;
    assign item_ready = (cnt_reg <= 3'd2);
    assign result_valid = (cnt_reg != 3'd0);
    assign pop = result_valid && result_ready;

    always_comb
    begin
        logic [17:0] p;
        logic [17:0] l;
        logic [17:0] b18;
        logic [15:0] t;
        logic        do_label;
        logic        lfirst;
        logic        lans;
        logic        found;
        logic [QIW-1:0] hit;

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        qtot_next   = qtot_reg;
        atot_next   = atot_reg;
        cq_next     = cq_reg;
        adone_next  = adone_reg;
        label_next  = label_reg;
        nlen_next   = nlen_reg;
        fw_next     = fw_reg;
        rtype_next  = rtype_reg;
        skip_next   = skip_reg;
        acc_hi_next = acc_hi_reg;
        acc_lo_next = acc_lo_reg;
        src_next    = src_reg;
        inl_next    = inl_reg;
        off_we      = 1'b0;
        off_idx     = '0;
        res_a[0]    = '0;
        res_a[1]    = '0;
        nres        = 2'd0;
        do_label    = 1'b0;
        lfirst      = 1'b0;
        lans        = 1'b0;
        found       = 1'b0;
        hit         = '0;
        t           = '0;
        b18         = {10'd0, data_byte};

        if (accept && msg_start)
        begin
            pos_next   = '0;
            len_next   = msg_len;
            phase_next = PH_HDR;
            qtot_next  = '0;
            atot_next  = '0;
            cq_next    = '0;
            adone_next = '0;
            label_next = '0;
            nlen_next  = '0;
            fw_next    = '0;
            rtype_next = '0;
            skip_next  = '0;
        end
        p = {2'd0, pos_next};
        l = {2'd0, len_next};

        if (accept && phase_next != PH_IDLE)
        begin
            unique case (phase_next)
                PH_HDR:
                begin
                    if (p == 18'd0)
                    begin
                        if (l < 18'd32)
                        begin
                            res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                            nres = nres + 2'd1;
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (p == 18'd2)
                    begin
                        if (data_byte[7] == 1'b0)
                        begin
                            res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                            nres = nres + 2'd1;
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (p == 18'd3)
                    begin
                        if (data_byte[3:0] != 4'd0)
                        begin
                            res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                            nres = nres + 2'd1;
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (p == 18'd4 || p == 18'd6)
                    begin
                        fw_next = {data_byte, 8'd0};
                    end
                    else if (p == 18'd5)
                    begin
                        t = fw_reg | {8'd0, data_byte};
                        if (t == 16'd0 || 32'(t) > MAX_QUERIES)
                        begin
                            res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                            nres = nres + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            qtot_next = QW'(t);
                        end
                    end
                    else if (p == 18'd7)
                    begin
                        t = fw_reg | {8'd0, data_byte};
                        if (t == 16'd0)
                        begin
                            res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                            nres = nres + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else if (32'(t) > MAX_ANSWERS)
                        begin
                            atot_next = AW'(MAX_ANSWERS);
                        end
                        else
                        begin
                            atot_next = AW'(t);
                        end
                    end
                    else if (p >= 18'd11)
                    begin
                        cq_next    = '0;
                        phase_next = PH_QSTART;
                    end
                end
                PH_QSTART:
                begin
                    if (p + 18'd5 >= l)
                    begin
                        res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                        nres = nres + 2'd1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        if (32'(cq_reg) < MAX_QUERIES)
                        begin
                            off_we  = 1'b1;
                            off_idx = QIW'(cq_reg);
                        end
                        nlen_next = '0;
                        do_label  = 1'b1;
                        lfirst    = 1'b1;
                    end
                end
                PH_QLEN:
                begin
                    do_label = 1'b1;
                end
                PH_QCHR, PH_ACHR:
                begin
                    if (nlen_next < NAME_LIMIT)
                    begin
                        res_a[nres[0]] = make_result((phase_next == PH_ACHR) ? KIND_ACHAR
                                                     : KIND_QCHAR, data_byte, '0, 1'b0, '0, '0);
                        nres = nres + 2'd1;
                        nlen_next = nlen_next + NW'(1);
                    end
                    if (label_next != 8'd0)
                    begin
                        label_next = label_next - 8'd1;
                    end
                    if (label_next == 8'd0)
                    begin
                        phase_next = (phase_next == PH_ACHR) ? PH_ALEN : PH_QLEN;
                    end
                end
                PH_QFIX:
                begin
                    if (skip_next != 16'd0)
                    begin
                        skip_next = skip_next - 16'd1;
                    end
                    if (skip_next == 16'd0)
                    begin
                        cq_next = cq_reg + QW'(1);
                        if (cq_next >= qtot_reg)
                        begin
                            adone_next = '0;
                            phase_next = PH_ASTART;
                        end
                        else
                        begin
                            phase_next = PH_QSTART;
                        end
                    end
                end
                PH_ASTART:
                begin
                    if (p + 18'd15 > l)
                    begin
                        res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                        nres = nres + 2'd1;
                        phase_next = PH_IDLE;
                    end
                    else if (data_byte[7:6] == 2'b11)
                    begin
                        inl_next   = 1'b0;
                        fw_next    = {12'd0, data_byte[3:0]};
                        phase_next = PH_APTR;
                    end
                    else if (p + 18'd5 >= l)
                    begin
                        res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                        nres = nres + 2'd1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        inl_next  = 1'b1;
                        nlen_next = '0;
                        do_label  = 1'b1;
                        lfirst    = 1'b1;
                        lans      = 1'b1;
                    end
                end
                PH_APTR:
                begin
                    t = {fw_reg[7:0], data_byte};
                    src_next = '0;
                    for (int j = MAX_QUERIES - 1; j >= 0; j--)
                    begin
                        if (32'(j) < 32'(qtot_reg) && qoff_reg[j] == t)
                        begin
                            found = 1'b1;
                            hit   = QIW'(j);
                        end
                    end
                    if (qtot_reg > QW'(1))
                    begin
                        if (!found)
                        begin
                            res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                            nres = nres + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            src_next   = hit;
                            phase_next = PH_TYPEHI;
                        end
                    end
                    else
                    begin
                        phase_next = PH_TYPEHI;
                    end
                end
                PH_ALEN:
                begin
                    do_label = 1'b1;
                    lans     = 1'b1;
                end
                PH_TYPEHI, PH_RDHI:
                begin
                    fw_next    = {data_byte, 8'd0};
                    phase_next = (phase_next == PH_TYPEHI) ? PH_TYPELO : PH_RDLO;
                end
                PH_TYPELO:
                begin
                    t = fw_reg | {8'd0, data_byte};
                    rtype_next = t;
                    if ((t == TYPE_A && p + 18'd13 <= l)
                        || (t == TYPE_AAAA && p + 18'd25 <= l)
                        || (t == TYPE_CNAME && qtot_reg == QW'(1) && p + 18'd9 <= l))
                    begin
                        skip_next  = 16'd6;
                        phase_next = PH_FIX;
                    end
                    else
                    begin
                        res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                        nres = nres + 2'd1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_FIX:
                begin
                    if (skip_next != 16'd0)
                    begin
                        skip_next = skip_next - 16'd1;
                    end
                    if (skip_next == 16'd0)
                    begin
                        phase_next = PH_RDHI;
                    end
                end
                PH_RDLO:
                begin
                    t = fw_reg | {8'd0, data_byte};
                    if (rtype_reg == TYPE_A || rtype_reg == TYPE_AAAA)
                    begin
                        if (t != ((rtype_reg == TYPE_A) ? 16'd4 : 16'd16))
                        begin
                            res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                            nres = nres + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            skip_next   = t;
                            acc_hi_next = '0;
                            acc_lo_next = '0;
                            phase_next  = PH_ADDR;
                        end
                    end
                    else
                    begin
                        adone_next = adone_reg + AW'(1);
                        if (adone_next >= atot_reg)
                        begin
                            res_a[nres[0]] = make_result(KIND_DONE, '0, '0, 1'b0, '0, '0);
                            nres = nres + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else if (p + 18'd16 + {2'd0, t} > l)
                        begin
                            res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                            nres = nres + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else if (t == 16'd0)
                        begin
                            phase_next = PH_ASTART;
                        end
                        else
                        begin
                            skip_next  = t;
                            phase_next = PH_CSKIP;
                        end
                    end
                end
                PH_ADDR:
                begin
                    acc_hi_next = {acc_hi_reg[55:0], acc_lo_reg[63:56]};
                    acc_lo_next = {acc_lo_reg[55:0], data_byte};
                    if (skip_next != 16'd0)
                    begin
                        skip_next = skip_next - 16'd1;
                    end
                    if (skip_next == 16'd0)
                    begin
                        res_a[nres[0]] = make_result(inl_reg ? KIND_MAP_INL : KIND_MAP_Q, '0,
                                                     inl_reg ? 3'd0 : 3'(src_reg),
                                                     (rtype_reg == TYPE_AAAA),
                                                     acc_hi_next, acc_lo_next);
                        nres = nres + 2'd1;
                        adone_next = adone_reg + AW'(1);
                        if (adone_next >= atot_reg)
                        begin
                            res_a[nres[0]] = make_result(KIND_DONE, '0, '0, 1'b0, '0, '0);
                            nres = nres + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_ASTART;
                        end
                    end
                end
                PH_CSKIP:
                begin
                    if (skip_next != 16'd0)
                    begin
                        skip_next = skip_next - 16'd1;
                    end
                    if (skip_next == 16'd0)
                    begin
                        phase_next = PH_ASTART;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (do_label)
            begin
                if ((!lfirst && p + 18'd4 >= l) || (p + 18'd1 + b18 >= l))
                begin
                    res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                    nres = nres + 2'd1;
                    phase_next = PH_IDLE;
                end
                else if (data_byte == 8'd0)
                begin
                    if (nlen_next == '0 || (!lans && p + 18'd5 >= l))
                    begin
                        res_a[nres[0]] = make_result(KIND_ABORT, '0, '0, 1'b0, '0, '0);
                        nres = nres + 2'd1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        res_a[nres[0]] = make_result(lans ? KIND_AEND : KIND_QEND, '0, '0,
                                                     1'b0, '0, '0);
                        nres = nres + 2'd1;
                        if (lans)
                        begin
                            phase_next = PH_TYPEHI;
                        end
                        else
                        begin
                            skip_next  = 16'd4;
                            phase_next = PH_QFIX;
                        end
                    end
                end
                else
                begin
                    if (!lfirst && nlen_next < NAME_LIMIT)
                    begin
                        res_a[nres[0]] = make_result(lans ? KIND_ACHAR : KIND_QCHAR, CHAR_DOT,
                                                     '0, 1'b0, '0, '0);
                        nres = nres + 2'd1;
                        nlen_next = nlen_next + NW'(1);
                    end
                    label_next = data_byte;
                    phase_next = lans ? PH_ACHR : PH_QCHR;
                end
            end

            pos_next = pos_next + 16'd1;
        end

        if (nres == 2'd1)
        begin
            res_a[0].last_of_run = 1'b1;
        end
        else if (nres == 2'd2)
        begin
            res_a[1].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            len_reg    <= '0;
            qtot_reg   <= '0;
            atot_reg   <= '0;
            cq_reg     <= '0;
            adone_reg  <= '0;
            label_reg  <= '0;
            nlen_reg   <= '0;
            fw_reg     <= '0;
            rtype_reg  <= '0;
            skip_reg   <= '0;
            acc_hi_reg <= '0;
            acc_lo_reg <= '0;
            src_reg    <= '0;
            inl_reg    <= 1'b0;
            wr_reg     <= '0;
            rd_reg     <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            qtot_reg   <= qtot_next;
            atot_reg   <= atot_next;
            cq_reg     <= cq_next;
            adone_reg  <= adone_next;
            label_reg  <= label_next;
            nlen_reg   <= nlen_next;
            fw_reg     <= fw_next;
            rtype_reg  <= rtype_next;
            skip_reg   <= skip_next;
            acc_hi_reg <= acc_hi_next;
            acc_lo_reg <= acc_lo_next;
            src_reg    <= src_next;
            inl_reg    <= inl_next;
            wr_reg     <= wr_reg + nres;
            rd_reg     <= rd_reg + {1'b0, pop};
            cnt_reg    <= cnt_reg + {1'b0, nres} - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (off_we)
        begin
            qoff_reg[off_idx] <= pos_reg;
        end
        if (nres != 2'd0)
        begin
            fifo_reg[wr_reg] <= res_a[0];
        end
        if (nres == 2'd2)
        begin
            fifo_reg[wr_reg + 2'd1] <= res_a[1];
        end
    end

    assign kind        = fifo_reg[rd_reg].kind;
    assign name_char   = fifo_reg[rd_reg].name_char;
    assign query_index = fifo_reg[rd_reg].query_index;
    assign is_ipv6     = fifo_reg[rd_reg].is_ipv6;
    assign addr_high   = fifo_reg[rd_reg].addr_high;
    assign addr_low    = fifo_reg[rd_reg].addr_low;
    assign last_of_run = fifo_reg[rd_reg].last_of_run;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("Result queue holds more than four entries.");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !msg_start && phase_reg == PH_IDLE) |=> cnt_reg <= $past(cnt_reg))
        else $error("A byte taken while idle produced a result.");

    a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && msg_start) |=> pos_reg == 16'd1)
        else $error("Byte position not restarted by a new message.");

endmodule
